### rtl/core/rcri_pkg.sv
// Shared types and constants for the rounded corner row inset block.
// Used by the channel interfaces, the square-root pipeline and the top level.
package rcri_pkg;

  localparam int DIM_BITS_DEF = 15;

  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_WIN_WIDTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIN_HEIGHT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CORNER_RADIUS = 2'd2;

  // per-row flags that ride along the root pipeline
  typedef struct packed {
    logic outside;
    logic in_band;
  } tag_t;

endpackage

### rtl/core/rcri_if.sv
// Valid/ready channel interfaces for row requests and span results.
// Depends on rcri_pkg for the default dimension width.
interface rcri_in_if #(
  parameter int DIM_BITS = rcri_pkg::DIM_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] row_index;

  modport source (output valid, output row_index, input ready);
  modport sink   (input valid, input row_index, output ready);
endinterface

interface rcri_out_if #(
  parameter int DIM_BITS = rcri_pkg::DIM_BITS_DEF
);
  logic                valid;
  logic                ready;
  logic                no_mask;
  logic                row_outside;
  logic [DIM_BITS-2:0] span_start;
  logic [DIM_BITS-1:0] span_width;

  modport source (output valid, output no_mask, output row_outside, output span_start,
                  output span_width, input ready);
  modport sink   (input valid, input no_mask, input row_outside, input span_start,
                  input span_width, output ready);
endinterface

### rtl/core/rounded_corner_row_inset_core.sv
// Rounded-rectangle mask: one visible row span per row index.
// Depends on rcri_pkg, rcri_if (channel interfaces) and rcri_isqrt.
//
//  channel  dir  beat fields
//  rows     in   row_index
//  spans    out  no_mask, row_outside, span_start, span_width
//  cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// One row per cycle while the skid entry is empty. Stages: input register,
// edge/term stage, multiplier stage, DIM_BITS square-root stages, output register.
// rst is synchronous and clears the valids, the three config registers, r_eff and none_q.
// The pipeline moves as one; it halts only while the skid entry holds a beat,
// so ready is a register and no beat is dropped or repeated across a stall.
module rounded_corner_row_inset_core #(
  parameter int DIM_BITS = rcri_pkg::DIM_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  rcri_in_if.sink                        rows,
  rcri_out_if.source                     spans,
  input  logic                           cfg_we,
  input  logic [rcri_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [DIM_BITS-1:0]            cfg_data
);

  localparam int N = DIM_BITS;

  // configuration and values derived from it
  logic [N-1:0] win_width;
  logic [N-1:0] win_height;
  logic [N-2:0] corner_radius;
  logic [N-2:0] r_eff;
  logic         none_q;
  logic [N-2:0] lim;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_width     <= '0;
      win_height    <= '0;
      corner_radius <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rcri_pkg::REG_WIN_WIDTH:     win_width     <= cfg_data;
        rcri_pkg::REG_WIN_HEIGHT:    win_height    <= cfg_data;
        rcri_pkg::REG_CORNER_RADIUS: corner_radius <= cfg_data[N-2:0];
        default: ;
      endcase
    end
  end

  assign lim = (win_height[N-1:1] < win_width[N-1:1]) ? win_height[N-1:1]
                                                      : win_width[N-1:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      r_eff  <= '0;
      none_q <= 1'b0;
    end else begin
      r_eff  <= (corner_radius > lim) ? lim : corner_radius;
      none_q <= (corner_radius == '0) || (win_width == '0) || (win_height == '0);
    end
  end

  // flow control
  logic en;
  logic skid_valid;
  assign en         = !skid_valid;
  assign rows.ready = en;

  // stage 1: input register
  logic         v1;
  logic [N-1:0] y_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= rows.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_q <= rows.row_index;
    end
  end

  // stage 2: edge distance and the two factors of 4r^2 - d^2 = (2e+1)(4r-2e-1)
  logic [N-1:0]   edge_dist;
  logic [N-1:0]   a_term;
  logic [N:0]     b_term;
  rcri_pkg::tag_t tag1;
  logic           v2;
  logic [N-1:0]   a_q;
  logic [N:0]     b_q;
  rcri_pkg::tag_t tag2;

  assign edge_dist    = (y_q < {1'b0, r_eff}) ? y_q : (win_height - {{(N-1){1'b0}}, 1'b1} - y_q);
  assign tag1.outside = (y_q >= win_height);
  assign tag1.in_band = (edge_dist < {1'b0, r_eff});
  assign a_term       = {edge_dist[N-2:0], 1'b1};
  assign b_term       = {r_eff, 2'b00} - {1'b0, a_term};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_q  <= a_term;
      b_q  <= b_term;
      tag2 <= tag1;
    end
  end

  // stage 3: discriminant product
  logic [2*N:0]   prod;
  logic           v3;
  logic [2*N-1:0] disc_q;
  rcri_pkg::tag_t tag3;

  assign prod = {{(N+1){1'b0}}, a_q} * {{N{1'b0}}, b_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc_q <= prod[2*N-1:0];
      tag3   <= tag2;
    end
  end

  // square-root stages
  logic           vr;
  logic [N-1:0]   root;
  rcri_pkg::tag_t tagr;

  rcri_isqrt #(.N(N)) u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .in_val    (disc_q),
    .in_tag    (tag3),
    .out_valid (vr),
    .out_root  (root),
    .out_tag   (tagr)
  );

  // result: inset = r - floor(root/2), span = width - 2*inset
  logic [N-2:0] inset_raw;
  logic [N-2:0] inset;
  logic [N-1:0] span;

  assign inset_raw = r_eff - root[N-1:1];
  assign inset     = (tagr.outside || none_q || !tagr.in_band) ? '0 : inset_raw;
  assign span      = tagr.outside ? '0 : (win_width - {inset, 1'b0});

  // output register plus one skid entry
  logic         out_free;
  logic         skid_none;
  logic         skid_outside;
  logic [N-2:0] skid_start;
  logic [N-1:0] skid_width;

  assign out_free = !spans.valid || spans.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      spans.valid <= 1'b0;
      skid_valid  <= 1'b0;
    end else if (skid_valid) begin
      if (out_free) begin
        spans.valid <= 1'b1;
        skid_valid  <= 1'b0;
      end
    end else if (out_free) begin
      spans.valid <= vr;
    end else if (vr) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_free) begin
        spans.no_mask     <= skid_none;
        spans.row_outside <= skid_outside;
        spans.span_start  <= skid_start;
        spans.span_width  <= skid_width;
      end
    end else if (out_free) begin
      spans.no_mask     <= none_q;
      spans.row_outside <= tagr.outside;
      spans.span_start  <= inset;
      spans.span_width  <= span;
    end else begin
      skid_none    <= none_q;
      skid_outside <= tagr.outside;
      skid_start   <= inset;
      skid_width   <= span;
    end
  end

  // checks
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> spans.valid)
    else $error("skid entry holds a beat while output is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    skid_valid && !spans.ready |=> skid_valid)
    else $error("skid entry dropped under stall");

  a_outside_zero: assert property (@(posedge clk) disable iff (rst)
    spans.valid && spans.row_outside |-> spans.span_start == '0 && spans.span_width == '0)
    else $error("row outside window carries a span");

  a_span_sum: assert property (@(posedge clk) disable iff (rst)
    spans.valid && !spans.row_outside |->
      ({1'b0, spans.span_width} + {1'b0, spans.span_start, 1'b0}) == {1'b0, win_width})
    else $error("span width and insets do not add up to window width");

  a_no_mask_full: assert property (@(posedge clk) disable iff (rst)
    spans.valid && spans.no_mask && !spans.row_outside |-> spans.span_start == '0)
    else $error("removed mask still insets the row");

endmodule

### rtl/core/rcri_isqrt.sv
// Pipelined integer square root, one result bit per stage, with a flag tag.
// Depends on rcri_pkg for tag_t.
module rcri_isqrt #(
  parameter int N = rcri_pkg::DIM_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [2*N-1:0]      in_val,
  input  rcri_pkg::tag_t      in_tag,
  output logic                out_valid,
  output logic [N-1:0]        out_root,
  output rcri_pkg::tag_t      out_tag
);

  logic [2*N-1:0]      val  [1:N-1];
  logic [N-1:0]        rem  [1:N-1];
  logic [N-1:0]        root [1:N];
  logic                vld  [1:N];
  rcri_pkg::tag_t      tag  [1:N];

  genvar k;
  for (k = 0; k < N; k++) begin : g_stage
    logic [2*N-1:0]  src_val;
    logic [N-1:0]    src_rem;
    logic [N-1:0]    src_root;
    logic            src_vld;
    rcri_pkg::tag_t  src_tag;
    logic [N+1:0]    cur;
    logic [N+1:0]    trial;
    logic            take;

    if (k == 0) begin : g_first
      assign src_val  = in_val;
      assign src_rem  = '0;
      assign src_root = '0;
      assign src_vld  = in_valid;
      assign src_tag  = in_tag;
    end else begin : g_next
      assign src_val  = val[k];
      assign src_rem  = rem[k];
      assign src_root = root[k];
      assign src_vld  = vld[k];
      assign src_tag  = tag[k];
    end

    // bring down the next pair of radicand bits, try (2*root)*2 + 1
    assign cur   = {src_rem, src_val[2*(N-1-k)+1 -: 2]};
    assign trial = {src_root, 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (en) begin
        vld[k+1] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root[k+1] <= {src_root[N-2:0], take};
        tag[k+1]  <= src_tag;
      end
    end

    if (k < N-1) begin : g_carry
      logic [N+1:0] diff;

      assign diff = take ? (cur - trial) : cur;

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= diff[N-1:0];
          val[k+1] <= src_val;
        end
      end
    end
  end

  assign out_valid = vld[N];
  assign out_root  = root[N];
  assign out_tag   = tag[N];

endmodule

### dv/testbench.sv
// Self-checking bench for rounded_corner_row_inset_core: random and directed row requests,
// per-row span prediction with an exact integer square root, scoreboard on the span channel.
// Depends on rcri_pkg, the rcri_in_if/rcri_out_if interfaces and the core RTL.
module testbench;

  localparam int DW = rcri_pkg::DIM_BITS_DEF;
  localparam int LAT = DW + 4;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [rcri_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [DW-1:0] row;
    logic          no_mask;
    logic          row_outside;
    logic [DW-2:0] span_start;
    logic [DW-1:0] span_width;
  } row_span_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [rcri_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [DW-1:0] cfg_data = '0;

  rcri_in_if  #(.DIM_BITS(DW)) row_ch ();
  rcri_out_if #(.DIM_BITS(DW)) span_ch ();

  rounded_corner_row_inset_core #(.DIM_BITS(DW)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .rows      (row_ch),
    .spans     (span_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // mirror of the window registers
  logic [DW-1:0] cur_w = '0;
  logic [DW-1:0] cur_h = '0;
  logic [DW-2:0] cur_r = '0;

  logic [DW-1:0] pending_rows[$];
  row_span_t     span_expect[$];
  int            errors = 0;
  int            quiet = 0;
  bit            row_taken = 1'b0;
  bit            span_taken = 1'b0;
  bit            idle_on = 1'b1;
  bit            calm = 1'b0;
  int            src_gap = 0;
  int            snk_gap = 0;

  logic [DW-1:0] band_rows [11] = '{15'd0, 15'd1, 15'd2, 15'd4, 15'd5, 15'd6, 15'd7,
                                    15'd10, 15'd11, 15'd12, 15'h7FFF};

  initial begin
    row_ch.valid = 1'b0;
    row_ch.row_index = '0;
    span_ch.ready = 1'b0;
  end

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned floor_root(int unsigned v);
    int unsigned acc, trial;
    acc = 0;
    for (int b = 15; b >= 0; b--) begin
      trial = acc | (32'd1 << b);
      if (trial * trial <= v) acc = trial;
    end
    return acc;
  endfunction

  function automatic row_span_t predict_span(logic [DW-1:0] row);
    row_span_t s;
    int unsigned y, w, h, r, lim, ed, d, inset, span;
    y = 32'(row);
    w = 32'(cur_w);
    h = 32'(cur_h);
    r = 32'(cur_r);
    inset = 0;
    span = 0;
    s.row = row;
    s.no_mask = (r == 0) || (w == 0) || (h == 0);
    s.row_outside = (y >= h);
    if (!s.row_outside) begin
      if (!s.no_mask) begin
        lim = (w / 2 < h / 2) ? w / 2 : h / 2;
        if (r > lim) r = lim;
        ed = (y < r) ? y : h - 1 - y;
        // half-pixel center folded into the doubled terms
        if (ed < r) begin
          d = 2 * r - 2 * ed - 1;
          inset = r - floor_root(4 * r * r - d * d) / 2;
        end
      end
      span = w - 2 * inset;
    end
    s.span_start = inset[DW-2:0];
    s.span_width = span[DW-1:0];
    return s;
  endfunction

  function automatic logic [DW-1:0] pick_row();
    int unsigned h, b, k;
    h = 32'(cur_h);
    b = 32'(cur_r);
    if (32'(cur_w) / 2 < b) b = 32'(cur_w) / 2;
    if (h / 2 < b) b = h / 2;
    if (h == 0 || $urandom_range(0, 99) < 15) return DW'($urandom_range(0, 32767));
    if ($urandom_range(0, 99) < 5) return DW'(h);
    if ($urandom_range(0, 99) < 30) return DW'($urandom_range(0, h - 1));
    // mostly hit the corner bands
    k = $urandom_range(0, b + 1);
    if (k > h - 1) k = h - 1;
    return $urandom_range(0, 1) ? DW'(k) : DW'(h - 1 - k);
  endfunction

  task automatic reg_write(input logic [rcri_pkg::CFG_IDX_W-1:0] idx,
                           input logic [DW-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      rcri_pkg::REG_WIN_WIDTH:     cur_w = data;
      rcri_pkg::REG_WIN_HEIGHT:    cur_h = data;
      rcri_pkg::REG_CORNER_RADIUS: cur_r = data[DW-2:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_window(input int unsigned w, input int unsigned h, input int unsigned r);
    reg_write(rcri_pkg::REG_WIN_WIDTH, w[DW-1:0]);
    reg_write(rcri_pkg::REG_WIN_HEIGHT, h[DW-1:0]);
    reg_write(rcri_pkg::REG_CORNER_RADIUS, r[DW-1:0]);
  endtask

  task automatic rand_window();
    int unsigned w, h, r;
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: w = 0;
          1: w = 1;
          2: w = 2;
          default: w = 32767;
        endcase
        case ($urandom_range(0, 3))
          0: h = 0;
          1: h = 1;
          2: h = 2;
          default: h = 32767;
        endcase
        case ($urandom_range(0, 2))
          0: r = 0;
          1: r = 1;
          default: r = 16383;
        endcase
      end
      7, 8: begin
        w = $urandom_range(0, 4000);
        h = $urandom_range(0, 4000);
        r = $urandom_range(0, 2100);
      end
      9: begin
        w = $urandom_range(0, 32767);
        h = $urandom_range(0, 32767);
        r = $urandom_range(0, 16383);
      end
      default: begin
        w = $urandom_range(0, 80);
        h = $urandom_range(0, 80);
        r = $urandom_range(0, 45);
      end
    endcase
    if ($urandom_range(0, 3) == 0) reg_write(REG_UNUSED, DW'($urandom_range(0, 32767)));
    // bit 14 of the radius write must be dropped
    set_window(w, h, r | ($urandom_range(0, 1) << 14));
  endtask

  task automatic drain();
    while (pending_rows.size() != 0 || row_ch.valid || span_expect.size() != 0)
      @(posedge clk);
    repeat (LAT + 6) @(posedge clk);
  endtask

  // row driver
  always @(negedge clk) begin
    logic          nv;
    logic [DW-1:0] nrow;
    nv = row_ch.valid;
    nrow = row_ch.row_index;
    if (!rst) begin
      if (row_taken) nv = 1'b0;
      if (!nv) begin
        if (src_gap > 0) begin
          src_gap--;
        end else if (pending_rows.size() != 0) begin
          if (idle_on && !calm && $urandom_range(0, 9) == 0) begin
            src_gap = $urandom_range(0, 11);
          end else begin
            nv = 1'b1;
            nrow = pending_rows.pop_front();
          end
        end
      end
    end
    row_ch.valid <= nv;
    row_ch.row_index <= nrow;
  end

  // span sink backpressure
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b0;
    if (!rst) begin
      if (snk_gap > 0) begin
        snk_gap--;
      end else if (idle_on && !calm && $urandom_range(0, 9) == 0) begin
        snk_gap = $urandom_range(0, 11);
      end else begin
        rdy = 1'b1;
      end
    end
    span_ch.ready <= rdy;
  end

  // monitor and scoreboard
  always @(posedge clk) begin
    row_span_t want;
    row_taken = !rst && row_ch.valid && row_ch.ready;
    span_taken = !rst && span_ch.valid && span_ch.ready;
    if (span_taken) begin
      if (span_expect.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("span beat with nothing expected: no_mask=%0b outside=%0b start=%0d width=%0d",
                   span_ch.no_mask, span_ch.row_outside, span_ch.span_start, span_ch.span_width);
      end else begin
        want = span_expect.pop_front();
        if (span_ch.no_mask !== want.no_mask || span_ch.row_outside !== want.row_outside ||
            span_ch.span_start !== want.span_start || span_ch.span_width !== want.span_width) begin
          errors++;
          if (errors <= 10) begin
            $display("row %0d (w=%0d h=%0d r=%0d): expected no_mask=%0b outside=%0b",
                     want.row, cur_w, cur_h, cur_r, want.no_mask, want.row_outside);
            $display("  expected start=%0d width=%0d", want.span_start, want.span_width);
            $display("  got no_mask=%0b outside=%0b start=%0d width=%0d",
                     span_ch.no_mask, span_ch.row_outside, span_ch.span_start, span_ch.span_width);
          end
        end
      end
    end
    if (row_taken) span_expect.push_back(predict_span(row_ch.row_index));
    quiet = (row_taken || span_taken) ? 0 : quiet + 1;
  end

  initial begin
    while (quiet < QUIET_LIMIT) @(posedge clk);
    $display("rounded_corner_row_inset_core verification failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers still at reset: mask removed
    pending_rows.push_back(15'd0);
    pending_rows.push_back(15'd5);
    pending_rows.push_back(15'h7FFF);
    drain();

    set_window(20, 12, 5);
    foreach (band_rows[i]) pending_rows.push_back(band_rows[i]);
    drain();

    // one-pixel window: radius clamps to zero but the mask stays
    set_window(1, 1, 5);
    pending_rows.push_back(15'd0);
    pending_rows.push_back(15'd1);
    drain();

    // largest window and radius, unused index must not disturb it
    set_window(32767, 32767, 15'h7FFF);
    reg_write(REG_UNUSED, '0);
    pending_rows.push_back(15'd0);
    pending_rows.push_back(15'd1);
    pending_rows.push_back(15'd16383);
    pending_rows.push_back(15'd16384);
    pending_rows.push_back(15'd32766);
    pending_rows.push_back(15'd32767);
    drain();

    // zero radius: full-width rows inside, nothing outside
    set_window(100, 50, 0);
    pending_rows.push_back(15'd0);
    pending_rows.push_back(15'd49);
    pending_rows.push_back(15'd50);
    drain();

    for (int p = 0; p < 26; p++) begin
      idle_on = ($urandom_range(0, 3) != 0);
      calm = (p == 25);
      rand_window();
      repeat (60) pending_rows.push_back(pick_row());
      drain();
    end

    if (errors == 0) begin
      $display("rounded_corner_row_inset_core verification clean");
    end else begin
      $display("rounded_corner_row_inset_core verification failed");
    end
    $finish;
  end

endmodule
